// ----- rtl/rau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes of the rational arithmetic unit
// Operation, status and order codes, plus the start/done words that the
// sequencer exchanges with its iterative gcd and divider units.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned DATA_BITS = 32;

  localparam logic [1:0] FUNC_REDUCE = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_SUB    = 2'd2;
  localparam logic [1:0] FUNC_CMP    = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

  localparam logic [1:0] ORDER_LESS    = 2'b11;
  localparam logic [1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [1:0] ORDER_GREATER = 2'b01;

  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic done;
  } unit_sts_t;

endpackage
`default_nettype wire

// ----- rtl/rau_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_mul: shared signed multiplier
// One signed operand pair per cycle; the full double-width product is
// registered and shows up in the next cycle.
// ----------------------------------------------------------------------------
module rau_mul #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic signed [WIDTH-1:0]   op_a,
  input  wire logic signed [WIDTH-1:0]   op_b,
  output logic signed [2*WIDTH-1:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule
`default_nettype wire

// ----- rtl/rau_gcd.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary gcd
// Stein's method, one shift or one subtract-and-halve per cycle. Both
// operands must be nonzero. Pulses done with the gcd held on g.
// ----------------------------------------------------------------------------
module rau_gcd #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rau_pkg::unit_ctl_t   ctl,
  input  wire logic [WIDTH-1:0]     x_in,
  input  wire logic [WIDTH-1:0]     y_in,
  output rau_pkg::unit_sts_t        sts,
  output logic [WIDTH-1:0]          g
);

  localparam int unsigned KW = $clog2(WIDTH);

  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [KW-1:0]    k;
  logic             running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        x       <= x_in;
        y       <= y_in;
        k       <= '0;
        running <= 1'b1;
      end else if (running) begin
        if (x == y) begin
          // restore the common power of two
          g        <= x << k;
          running  <= 1'b0;
          sts.done <= 1'b1;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + KW'(1);
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rau_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_div: dual restoring divider
// Divides two numerators by one common divisor, one quotient bit per lane
// per cycle. Pulses done with both quotients held.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rau_pkg::unit_ctl_t   ctl,
  input  wire logic [WIDTH-1:0]     num_a,
  input  wire logic [WIDTH-1:0]     num_b,
  input  wire logic [WIDTH-1:0]     divisor,
  output rau_pkg::unit_sts_t        sts,
  output logic [WIDTH-1:0]          quo_a,
  output logic [WIDTH-1:0]          quo_b
);

  localparam int unsigned CW = $clog2(WIDTH);

  logic [WIDTH-1:0] dv;
  logic [WIDTH-1:0] rem      [2];
  logic [WIDTH-1:0] quo      [2];
  logic [WIDTH:0]   trial    [2];
  logic [WIDTH-1:0] rem_next [2];
  logic             fits     [2];
  logic [CW-1:0]    cnt;
  logic             running;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i]    = {rem[i], quo[i][WIDTH-1]};
      fits[i]     = trial[i] >= {1'b0, dv};
      rem_next[i] = fits[i] ? WIDTH'(trial[i] - {1'b0, dv}) : trial[i][WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        dv      <= divisor;
        rem[0]  <= '0;
        rem[1]  <= '0;
        quo[0]  <= num_a;
        quo[1]  <= num_b;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        for (int i = 0; i < 2; i++) begin
          rem[i] <= rem_next[i];
          quo[i] <= {quo[i][WIDTH-2:0], fits[i]};
        end
        cnt <= cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          running  <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  assign quo_a = quo[0];
  assign quo_b = quo[1];

endmodule
`default_nettype wire

// ----- rtl/rational_arith_unit_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arith_unit_top: rational-number reduce, add, subtract, compare
// Sequence: a zero denominator goes straight to the output; compare orders
//   the cross products; reduce, add and subtract run the binary gcd, then
//   divide both double-width magnitudes by it.
// Throughput: one word at a time; in_ready returns the cycle after the result
//   is loaded into the output register. The gcd loop is the longest step.
// Reset: synchronous, active high; clears only control state and out_valid.
// ----------------------------------------------------------------------------
module rational_arith_unit_top #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           func,
  input  wire logic signed [rau_pkg::DATA_BITS-1:0] a_numer,
  input  wire logic signed [rau_pkg::DATA_BITS-1:0] a_denom,
  input  wire logic signed [rau_pkg::DATA_BITS-1:0] b_numer,
  input  wire logic signed [rau_pkg::DATA_BITS-1:0] b_denom,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [rau_pkg::DATA_BITS-1:0]      res_numer,
  output logic signed [rau_pkg::DATA_BITS-1:0]      res_denom,
  output logic signed [1:0]                         order,
  output logic [1:0]                                status
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned W2 = 2 * WORD_BITS;
  localparam int unsigned DB = rau_pkg::DATA_BITS;
  // smallest magnitude that no longer fits as a positive word
  localparam logic [W2-1:0] LIM = W2'(1) << (WORD_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_Q,
    S_MUL_D,
    S_SUM,
    S_MAG,
    S_GSTART,
    S_GWAIT,
    S_DSTART,
    S_DWAIT,
    S_CHK,
    S_FIN
  } state_t;

  state_t state;

  // operands, taken as their low WORD_BITS bits
  logic signed [W-1:0] in_an, in_ad, in_bd;
  logic signed [W-1:0] an, ad, bn, bd;
  logic [1:0]          fcode;

  // cross products and the signed value to reduce
  logic signed [W2-1:0] pp, qq;
  logic signed [W2:0]   sval;
  logic signed [W2-1:0] dval;
  logic                 neg;
  logic [W2-1:0]        nm, dm;

  // staged result word, waits here until the output register is free
  logic signed [DB-1:0] w_numer, w_denom;
  logic [1:0]           w_order, w_status;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [W2-1:0] prod;

  rau_pkg::unit_ctl_t gctl, dctl;
  rau_pkg::unit_sts_t gsts, dsts;
  logic [W2-1:0]      gcd_val;
  logic [W2-1:0]      qn, qd;

  logic                 zero_den;
  logic [W2:0]          mag_s;
  logic [W2-1:0]        mag_d;
  logic signed [W2:0]   pp_ext, qq_ext;
  logic                 gt, lt, flip;
  logic [1:0]           cmp_order;
  logic [W2-1:0]        snum;
  logic signed [W-1:0]  tnum;
  logic                 ovf;

  assign in_an = signed'(a_numer[W-1:0]);
  assign in_ad = signed'(a_denom[W-1:0]);
  assign in_bd = signed'(b_denom[W-1:0]);

  assign in_ready = (state == S_IDLE);

  // a zero denominator short-cuts everything
  assign zero_den = (in_ad == '0) || ((func != rau_pkg::FUNC_REDUCE) && (in_bd == '0));

  // steer the shared multiplier: an*bd, then bn*ad, then ad*bd
  always_comb begin
    unique case (state)
      S_MUL_P: begin
        mul_a = an;
        mul_b = bd;
      end
      S_MUL_Q: begin
        mul_a = bn;
        mul_b = ad;
      end
      default: begin
        mul_a = ad;
        mul_b = bd;
      end
    endcase
  end

  rau_mul #(.WIDTH(W)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // compare: order of the cross products, turned around when the
  // denominators differ in sign
  assign gt   = pp > qq;
  assign lt   = pp < qq;
  assign flip = ad[W-1] ^ bd[W-1];
  always_comb begin
    if ((gt && !flip) || (lt && flip)) begin
      cmp_order = rau_pkg::ORDER_GREATER;
    end else if (gt || lt) begin
      cmp_order = rau_pkg::ORDER_LESS;
    end else begin
      cmp_order = rau_pkg::ORDER_EQUAL;
    end
  end

  assign pp_ext = (W2 + 1)'(pp);
  assign qq_ext = (W2 + 1)'(qq);

  // magnitudes of the fraction to reduce
  assign mag_s = sval[W2] ? -sval : sval;
  assign mag_d = dval[W2-1] ? -dval : dval;

  rau_gcd #(.WIDTH(W2)) u_gcd (
    .clk  (clk),
    .rst  (rst),
    .ctl  (gctl),
    .x_in (nm),
    .y_in (dm),
    .sts  (gsts),
    .g    (gcd_val)
  );

  rau_div #(.WIDTH(W2)) u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (dctl),
    .num_a   (nm),
    .num_b   (dm),
    .divisor (gcd_val),
    .sts     (dsts),
    .quo_a   (qn),
    .quo_b   (qd)
  );

  assign gctl.start = (state == S_GSTART);
  assign dctl.start = (state == S_DSTART);

  // range check on the reduced fraction; the negative side reaches one further
  assign ovf  = (qd >= LIM) || (neg ? (qn > LIM) : (qn >= LIM));
  assign snum = neg ? -qn : qn;
  assign tnum = signed'(snum[W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // raise out_valid when the staged word moves out, drop it once taken
      if ((state == S_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            an       <= in_an;
            ad       <= in_ad;
            bn       <= signed'(b_numer[W-1:0]);
            bd       <= in_bd;
            fcode    <= func;
            w_numer  <= '0;
            w_denom  <= '0;
            w_order  <= rau_pkg::ORDER_EQUAL;
            w_status <= rau_pkg::STATUS_OK;
            if (zero_den) begin
              w_status <= rau_pkg::STATUS_ZERO_DEN;
              state    <= S_FIN;
            end else if (func == rau_pkg::FUNC_REDUCE) begin
              sval  <= (W2 + 1)'(in_an);
              dval  <= W2'(in_ad);
              state <= S_MAG;
            end else begin
              state <= S_MUL_P;
            end
          end
        end
        S_MUL_P: begin
          state <= S_MUL_Q;
        end
        S_MUL_Q: begin
          pp    <= prod;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          qq    <= prod;
          state <= S_SUM;
        end
        S_SUM: begin
          if (fcode == rau_pkg::FUNC_CMP) begin
            w_order <= cmp_order;
            state   <= S_FIN;
          end else begin
            sval  <= (fcode == rau_pkg::FUNC_SUB) ? pp_ext - qq_ext : pp_ext + qq_ext;
            dval  <= prod;
            state <= S_MAG;
          end
        end
        S_MAG: begin
          neg <= sval[W2] ^ dval[W2-1];
          nm  <= mag_s[W2-1:0];
          dm  <= mag_d;
          if (sval == '0) begin
            // zero numerator reduces to 0/1
            w_denom <= DB'(1);
            state   <= S_FIN;
          end else begin
            state <= S_GSTART;
          end
        end
        S_GSTART: begin
          state <= S_GWAIT;
        end
        S_GWAIT: begin
          if (gsts.done) begin
            state <= S_DSTART;
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (dsts.done) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (ovf) begin
            w_status <= rau_pkg::STATUS_OVERFLOW;
          end else begin
            w_numer <= DB'(tnum);
            w_denom <= DB'(qd[W-1:0]);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          // hold the word until the output register is free
          if (!out_valid || out_ready) begin
            res_numer <= w_numer;
            res_denom <= w_denom;
            order     <= w_order;
            status    <= w_status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
